>>> src/mcb_pkg.sv
`timescale 1ns / 1ps

package mcb_pkg;

  // Command codes on in_command
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Result codes on out_status
  typedef enum logic [2:0] {
    STAT_CARVED   = 3'd0,
    STAT_BACKTRK  = 3'd1,
    STAT_FINISHED = 3'd2,
    STAT_READ     = 3'd3,
    STAT_STARTED  = 3'd4
  } status_t;

  // Neighbor directions, probed in this order
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // Configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Reset value of both size registers
  localparam int SIZE_RESET = 64;

  // Control group from the sequencer to the grid memory
  typedef struct packed {
    logic clr;
    logic rd;
    logic wr;
  } grid_ctl_t;

  // Residue modulo 3: base-4 digits each weigh 1 mod 3, so fold digit sums
  function automatic logic [1:0] mod3(input logic [31:0] v);
    logic [5:0] s;
    logic [3:0] f;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 16; i++) begin
      s = s + 6'(v[2*i +: 2]);
    end
    f = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
    t = 3'(f[3:2]) + 3'(f[1:0]);
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

endpackage

>>> src/mcb_grid.sv
`timescale 1ns / 1ps

module mcb_grid import mcb_pkg::*; #(
  parameter int SIDE = 64,
  localparam int RW = $clog2(SIDE)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  grid_ctl_t       ctl,
  input  logic [RW-1:0]   row,
  input  logic [SIDE-1:0] wr_bits,
  output logic [SIDE-1:0] rd_data
);

  logic [SIDE-1:0] mem [SIDE];
  logic [SIDE-1:0] row_vld_r;
  logic [SIDE-1:0] rd_q_r;
  logic            rd_vld_r;

  // Track which rows hold data since the last clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (ctl.clr) begin
      row_vld_r <= '0;
    end else if (ctl.wr) begin
      row_vld_r[row] <= 1'b1;
    end
  end

  // Set bits in a row; a stale row is rewritten whole
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      for (int i = 0; i < SIDE; i++) begin
        if (wr_bits[i] || !row_vld_r[row]) mem[row][i] <= wr_bits[i];
      end
    end
    if (ctl.rd) begin
      rd_q_r   <= mem[row];
      rd_vld_r <= row_vld_r[row];
    end
  end

  // Stale rows read as all clear
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

>>> src/maze_carve_backtracker.sv
`timescale 1ns / 1ps
// A start command runs S_CLEAR and S_MARK, a read S_READ. A step probes four neighbors in S_PROBE,
// then S_TALLY reports a finish, S_POP a backtrack, S_PICK a sideways carve, and S_PICK plus S_WALL
// a carve up or down. Four neighbor probes share the one neighbor unit and the one grid row port.
// busy is low again in the cycle out_valid is high, so a new command can follow directly.
// Results are strobed for one cycle and cannot be stalled. Synchronous active-low reset
// empties the grid and stack and puts the walker at (0,0); no clearing pass is needed.
module maze_carve_backtracker import mcb_pkg::*; #(
  parameter int MAX_SIDE    = 64,
  parameter int STACK_DEPTH = 1024,
  parameter int RANDOM_BITS = 16,
  localparam int CW   = $clog2(MAX_SIDE),
  localparam int CFGW = $clog2(MAX_SIDE + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_command,
  input  logic [RANDOM_BITS-1:0] in_random_value,
  input  logic [CW-1:0]          in_read_x,
  input  logic [CW-1:0]          in_read_y,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [CW-1:0]          out_new_x,
  output logic [CW-1:0]          out_new_y,
  output logic [CW-1:0]          out_wall_x,
  output logic [CW-1:0]          out_wall_y,
  output logic                   out_cell_value,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFGW-1:0]        cfg_data
);

  localparam int SW   = $clog2(STACK_DEPTH);
  localparam int CMPW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_MARK, S_READ, S_PROBE, S_TALLY, S_PICK, S_WALL, S_POP
  } state_t;

  state_t state_r, state_nxt;

  logic [CFGW-1:0]        grid_w_r, grid_h_r;
  logic [CW-1:0]          walker_x_r, walker_x_nxt, walker_y_r, walker_y_nxt;
  logic [SW:0]            cnt_r, cnt_nxt;
  logic [1:0]             dir_r, dir_nxt;
  logic [1:0]             sel_dir_r, sel_dir_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic                   pend_inb_r, pend_inb_nxt;
  logic [CW-1:0]          pend_col_r, pend_col_nxt;
  logic [1:0]             pend_dir_r, pend_dir_nxt;
  logic [3:0]             open_r, open_nxt;
  logic [RANDOM_BITS-1:0] rnd_r, rnd_nxt;
  logic [1:0]             rmod3_r, rmod3_nxt;
  logic [CW-1:0]          wall_x_r, wall_x_nxt, wall_y_r, wall_y_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [CW-1:0]          out_new_x_r, out_new_x_nxt, out_new_y_r, out_new_y_nxt;
  logic [CW-1:0]          out_wall_x_r, out_wall_x_nxt, out_wall_y_r, out_wall_y_nxt;
  logic                   out_cell_r, out_cell_nxt;

  // Grid memory port
  grid_ctl_t              g_ctl;
  logic [CW-1:0]          g_row;
  logic [MAX_SIDE-1:0]    g_bits;
  logic [MAX_SIDE-1:0]    g_rd;

  // Stack memory
  logic [2*CW-1:0]        stack_mem [STACK_DEPTH];
  logic [2*CW-1:0]        stack_q_r;
  logic                   stk_wr, stk_rd;
  logic [SW-1:0]          stk_addr;

  // Effective sizes and neighbor unit
  logic [CMPW-1:0]        w_eff, h_eff;
  logic [1:0]             u_dir;
  logic                   u_vert, u_neg, u_inb;
  logic [CMPW-1:0]        u_base, u_other, u_lim, u_olim, u_s2, u_s1;
  logic [CW-1:0]          u_nx, u_ny, u_wx, u_wy;

  // Tally helpers
  logic [3:0]             open_now;
  logic [2:0]             n_open;
  logic [1:0]             pick, sel, k;
  logic                   found, rd_inb;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Hold the size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= CFGW'(SIZE_RESET);
      grid_h_r <= CFGW'(SIZE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_w_r <= cfg_data;
        REG_GRID_HEIGHT: grid_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate sizes into 1..MAX_SIDE
  always_comb begin
    if (grid_w_r == '0) w_eff = CMPW'(1);
    else if (CMPW'(grid_w_r) > CMPW'(MAX_SIDE)) w_eff = CMPW'(MAX_SIDE);
    else w_eff = CMPW'(grid_w_r);
    if (grid_h_r == '0) h_eff = CMPW'(1);
    else if (CMPW'(grid_h_r) > CMPW'(MAX_SIDE)) h_eff = CMPW'(MAX_SIDE);
    else h_eff = CMPW'(grid_h_r);
  end

  // Shared neighbor unit: one neighbor's coordinates and bounds compare per cycle
  always_comb begin
    u_dir   = (state_r == S_PICK) ? sel_dir_r : dir_r;
    u_vert  = (u_dir == DIR_UP) || (u_dir == DIR_DOWN);
    u_neg   = (u_dir == DIR_UP) || (u_dir == DIR_LEFT);
    u_base  = u_vert ? CMPW'(walker_y_r) : CMPW'(walker_x_r);
    u_other = u_vert ? CMPW'(walker_x_r) : CMPW'(walker_y_r);
    u_lim   = u_vert ? h_eff : w_eff;
    u_olim  = u_vert ? w_eff : h_eff;
    u_s2    = u_neg ? u_base - CMPW'(2) : u_base + CMPW'(2);
    u_s1    = u_neg ? u_base - CMPW'(1) : u_base + CMPW'(1);
    u_inb   = (!u_neg || u_base >= CMPW'(2)) && (u_s2 < u_lim) && (u_other < u_olim);
    u_nx    = u_vert ? walker_x_r : u_s2[CW-1:0];
    u_ny    = u_vert ? u_s2[CW-1:0] : walker_y_r;
    u_wx    = u_vert ? walker_x_r : u_s1[CW-1:0];
    u_wy    = u_vert ? u_s1[CW-1:0] : walker_y_r;
  end

  // Fold in the neighbor whose row arrived this cycle, then pick among open ones
  always_comb begin
    open_now = open_r;
    if (pend_vld_r) open_now[pend_dir_r] = pend_inb_r & ~g_rd[pend_col_r];
    n_open = 3'($countones(open_now));
    unique case (n_open)
      3'd2:    pick = {1'b0, rnd_r[0]};
      3'd3:    pick = rmod3_r;
      3'd4:    pick = rnd_r[1:0];
      default: pick = 2'd0;
    endcase
    sel   = 2'd0;
    k     = 2'd0;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (open_now[i] && !found) begin
        if (k == pick) begin
          sel   = 2'(i);
          found = 1'b1;
        end
        k = k + 2'd1;
      end
    end
  end

  assign rd_inb = (CMPW'(in_read_x) < w_eff) && (CMPW'(in_read_y) < h_eff);

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    walker_x_nxt   = walker_x_r;
    walker_y_nxt   = walker_y_r;
    cnt_nxt        = cnt_r;
    dir_nxt        = dir_r;
    sel_dir_nxt    = sel_dir_r;
    pend_vld_nxt   = pend_vld_r;
    pend_inb_nxt   = pend_inb_r;
    pend_col_nxt   = pend_col_r;
    pend_dir_nxt   = pend_dir_r;
    open_nxt       = open_r;
    rnd_nxt        = rnd_r;
    rmod3_nxt      = rmod3_r;
    wall_x_nxt     = wall_x_r;
    wall_y_nxt     = wall_y_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_new_x_nxt  = out_new_x_r;
    out_new_y_nxt  = out_new_y_r;
    out_wall_x_nxt = '0;
    out_wall_y_nxt = '0;
    out_cell_nxt   = 1'b0;
    g_ctl          = '0;
    g_row          = u_ny;
    g_bits         = '0;
    stk_wr         = 1'b0;
    stk_rd         = 1'b0;
    stk_addr       = cnt_r[SW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          rnd_nxt   = in_random_value;
          rmod3_nxt = mod3(32'(in_random_value));
          unique case (in_command)
            CMD_START: state_nxt = S_CLEAR;
            CMD_STEP: begin
              dir_nxt      = 2'd0;
              pend_vld_nxt = 1'b0;
              open_nxt     = '0;
              state_nxt    = S_PROBE;
            end
            CMD_READ: begin
              g_ctl.rd     = rd_inb;
              g_row        = in_read_y;
              pend_inb_nxt = rd_inb;
              pend_col_nxt = in_read_x;
              state_nxt    = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        g_ctl.clr    = 1'b1;
        walker_x_nxt = '0;
        walker_y_nxt = '0;
        cnt_nxt      = '0;
        state_nxt    = S_MARK;
      end
      S_MARK: begin
        // Mark the start cell and report
        g_ctl.wr       = 1'b1;
        g_row          = '0;
        g_bits         = MAX_SIDE'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_STARTED;
        out_new_x_nxt  = '0;
        out_new_y_nxt  = '0;
        state_nxt      = S_IDLE;
      end
      S_READ: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_READ;
        out_new_x_nxt  = walker_x_r;
        out_new_y_nxt  = walker_y_r;
        out_cell_nxt   = pend_inb_r & g_rd[pend_col_r];
        state_nxt      = S_IDLE;
      end
      S_PROBE: begin
        // Issue one neighbor row read, fold in the previous one
        g_ctl.rd     = u_inb;
        open_nxt     = open_now;
        pend_vld_nxt = 1'b1;
        pend_inb_nxt = u_inb;
        pend_col_nxt = u_nx;
        pend_dir_nxt = dir_r;
        dir_nxt      = dir_r + 2'd1;
        if (dir_r == DIR_RIGHT) state_nxt = S_TALLY;
      end
      S_TALLY: begin
        pend_vld_nxt = 1'b0;
        if (n_open == 3'd0) begin
          if (cnt_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FINISHED;
            out_new_x_nxt  = walker_x_r;
            out_new_y_nxt  = walker_y_r;
            state_nxt      = S_IDLE;
          end else begin
            // Pop the return stack
            stk_rd    = 1'b1;
            stk_addr  = SW'(cnt_r - (SW+1)'(1));
            cnt_nxt   = cnt_r - (SW+1)'(1);
            state_nxt = S_POP;
          end
        end else begin
          sel_dir_nxt = sel;
          state_nxt   = S_PICK;
        end
      end
      S_PICK: begin
        // Push unless the stack is full, move and mark the new cell (and the wall when on the same row)
        if (cnt_r != (SW+1)'(STACK_DEPTH)) begin
          stk_wr  = 1'b1;
          cnt_nxt = cnt_r + (SW+1)'(1);
        end
        walker_x_nxt = u_nx;
        walker_y_nxt = u_ny;
        g_ctl.wr     = 1'b1;
        g_row        = u_ny;
        g_bits       = MAX_SIDE'(1) << u_nx;
        if (u_vert) begin
          wall_x_nxt = u_wx;
          wall_y_nxt = u_wy;
          state_nxt  = S_WALL;
        end else begin
          g_bits         = g_bits | (MAX_SIDE'(1) << u_wx);
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_CARVED;
          out_new_x_nxt  = u_nx;
          out_new_y_nxt  = u_ny;
          out_wall_x_nxt = u_wx;
          out_wall_y_nxt = u_wy;
          state_nxt      = S_IDLE;
        end
      end
      S_WALL: begin
        g_ctl.wr       = 1'b1;
        g_row          = wall_y_r;
        g_bits         = MAX_SIDE'(1) << wall_x_r;
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_CARVED;
        out_new_x_nxt  = walker_x_r;
        out_new_y_nxt  = walker_y_r;
        out_wall_x_nxt = wall_x_r;
        out_wall_y_nxt = wall_y_r;
        state_nxt      = S_IDLE;
      end
      S_POP: begin
        walker_x_nxt   = stack_q_r[CW-1:0];
        walker_y_nxt   = stack_q_r[2*CW-1:CW];
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_BACKTRK;
        out_new_x_nxt  = stack_q_r[CW-1:0];
        out_new_y_nxt  = stack_q_r[2*CW-1:CW];
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walker_x_r  <= '0;
      walker_y_r  <= '0;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walker_x_r  <= walker_x_nxt;
      walker_y_r  <= walker_y_nxt;
      cnt_r       <= cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dir_r        <= dir_nxt;
    sel_dir_r    <= sel_dir_nxt;
    pend_inb_r   <= pend_inb_nxt;
    pend_col_r   <= pend_col_nxt;
    pend_dir_r   <= pend_dir_nxt;
    open_r       <= open_nxt;
    rnd_r        <= rnd_nxt;
    rmod3_r      <= rmod3_nxt;
    wall_x_r     <= wall_x_nxt;
    wall_y_r     <= wall_y_nxt;
    out_status_r <= out_status_nxt;
    out_new_x_r  <= out_new_x_nxt;
    out_new_y_r  <= out_new_y_nxt;
    out_wall_x_r <= out_wall_x_nxt;
    out_wall_y_r <= out_wall_y_nxt;
    out_cell_r   <= out_cell_nxt;
  end

  // Return stack: one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (stk_wr) stack_mem[stk_addr] <= {walker_y_r, walker_x_r};
    if (stk_rd) stack_q_r <= stack_mem[stk_addr];
  end

  mcb_grid #(
    .SIDE(MAX_SIDE)
  ) u_grid (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (g_ctl),
    .row     (g_row),
    .wr_bits (g_bits),
    .rd_data (g_rd)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_x      = out_new_x_r;
  assign out_new_y      = out_new_y_r;
  assign out_wall_x     = out_wall_x_r;
  assign out_wall_y     = out_wall_y_r;
  assign out_cell_value = out_cell_r;

endmodule

>>> src/mcb_checker.sv
`timescale 1ns / 1ps

module mcb_checker import mcb_pkg::*; #(
  parameter int MAX_SIDE    = 64,
  parameter int RANDOM_BITS = 16,
  localparam int CW   = $clog2(MAX_SIDE),
  localparam int CFGW = $clog2(MAX_SIDE + 1)
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic [1:0]             in_command,
  input logic [RANDOM_BITS-1:0] in_random_value,
  input logic [CW-1:0]          in_read_x,
  input logic [CW-1:0]          in_read_y,
  input logic                   out_valid,
  input logic [2:0]             out_status,
  input logic [CW-1:0]          out_new_x,
  input logic [CW-1:0]          out_new_y,
  input logic [CW-1:0]          out_wall_x,
  input logic [CW-1:0]          out_wall_y,
  input logic                   out_cell_value,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic                   cfg_index,
  input logic [CFGW-1:0]        cfg_data
);

  // A real command accepted while idle raises busy
  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == CMD_START || in_command == CMD_STEP ||
    in_command == CMD_READ) |=> busy)
    else $error("command transfer did not raise busy");

  // A result transfer comes exactly when busy drops
  a_res_fell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result strobe not aligned with end of busy");

  // Wall fields are clear unless a cell was carved
  a_wall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_CARVED |-> out_wall_x == '0 && out_wall_y == '0)
    else $error("wall fields set on a non-carve result");

  // Cell bit only on read results
  a_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_READ |-> !out_cell_value)
    else $error("cell bit set on a non-read result");

  // Start puts the walker at the origin
  a_start_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_STARTED |-> out_new_x == '0 && out_new_y == '0)
    else $error("start result with walker away from origin");

endmodule

bind maze_carve_backtracker mcb_checker #(
  .MAX_SIDE    (MAX_SIDE),
  .RANDOM_BITS (RANDOM_BITS)
) u_mcb_checker (.*);
